@@ rtl/core/fifo_first_free_slot_dispatcher_unit_macros.svh @@
// Assertion macros shared by the dispatcher's checker.
`ifndef FIFO_FIRST_FREE_SLOT_DISPATCHER_UNIT_MACROS_SVH
`define FIFO_FIRST_FREE_SLOT_DISPATCHER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FFSD_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dispatcher check failed: same-cycle rule");

// Next-cycle implication, disabled while reset is asserted.
`define FFSD_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dispatcher check failed: next-cycle rule");

`endif

@@ rtl/core/ffsd_pkg.sv @@
// Shared types and constants of the first-fit process dispatcher.
package ffsd_pkg;

    localparam int CPUS        = 2;
    localparam int CORES       = 2;
    localparam int THREADS     = 4;
    localparam int QUEUE_DEPTH = 16;

    localparam int NSLOTS  = CPUS * CORES * THREADS;
    localparam int SLOT_W  = (NSLOTS > 1) ? $clog2(NSLOTS) : 1;
    localparam int QIDX_W  = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W  = $clog2(QUEUE_DEPTH + 1);
    // Wide enough for any CPU, core or thread index up to seven.
    localparam int IDX_W   = 3;

    typedef enum logic {
        OP_SUBMIT = 1'b0,
        OP_TICK   = 1'b1
    } op_t;

    typedef enum logic [2:0] {
        KIND_QUEUED     = 3'd0,
        KIND_FULL       = 3'd1,
        KIND_DISPATCHED = 3'd2,
        KIND_REQUEUED   = 3'd3,
        KIND_FINISHED   = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EVAL,
        ST_DEQ,
        ST_DISP,
        ST_ZFIN,
        ST_FLUSH
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [15:0] pid;
        logic [15:0] lifetime;
    } in_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] proc_id;
        logic        cpu_index;
        logic        core_index;
        logic [1:0]  thread_index;
        logic        last;
    } out_t;

    typedef struct packed {
        logic [15:0] pid;
        logic [15:0] life;
    } ring_entry_t;

    typedef struct packed {
        logic [15:0] owner;
        logic [15:0] remaining;
    } slot_entry_t;

    typedef struct packed {
        logic push;
        logic pop;
    } ring_cmd_t;

    typedef struct packed {
        logic empty;
        logic full;
    } ring_stat_t;

    typedef struct packed {
        logic              wr_en;
        logic [SLOT_W-1:0] wr_addr;
        logic              set_busy;
        logic              clr_busy;
    } slot_cmd_t;

    typedef struct packed {
        logic push;
        logic flush;
    } res_cmd_t;

endpackage

@@ rtl/core/ffsd_ring.sv @@
// Ready ring: FIFO memory of waiting processes with head and count.
module ffsd_ring (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  ffsd_pkg::ring_cmd_t  cmd,
    input  ffsd_pkg::ring_entry_t wdata,
    output ffsd_pkg::ring_stat_t stat,
    output ffsd_pkg::ring_entry_t rdata
);
    import ffsd_pkg::*;

    ring_entry_t       mem [QUEUE_DEPTH];
    logic [QIDX_W-1:0] head_reg;
    logic [QIDX_W-1:0] head_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic [QIDX_W:0]   tail_sum;
    logic [QIDX_W-1:0] tail;

    // Tail position is head plus count, wrapped once.
    always_comb begin
        tail_sum = (QIDX_W + 1)'(head_reg) + (QIDX_W + 1)'(count_reg);
        if (tail_sum >= (QIDX_W + 1)'(QUEUE_DEPTH)) begin
            tail = QIDX_W'(tail_sum - (QIDX_W + 1)'(QUEUE_DEPTH));
        end else begin
            tail = QIDX_W'(tail_sum);
        end
    end

    // A pop advances the head; push and pop together keep the count.
    always_comb begin
        head_next  = head_reg;
        count_next = count_reg;
        if (cmd.pop) begin
            head_next = (head_reg == QIDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (cmd.push && !cmd.pop) begin
            count_next = count_reg + 1'b1;
        end else if (cmd.pop && !cmd.push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else begin
            head_reg  <= head_next;
            count_reg <= count_next;
        end
    end

    // Write at the tail, read the head entry every cycle.
    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            mem[tail] <= wdata;
        end
        rdata <= mem[head_reg];
    end

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));

endmodule

@@ rtl/core/ffsd_slot_table.sv @@
// Thread slot table: busy flags in flops, owner and lifetime in memory.
module ffsd_slot_table (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  ffsd_pkg::slot_cmd_t           cmd,
    input  ffsd_pkg::slot_entry_t         wdata,
    input  logic [ffsd_pkg::SLOT_W-1:0]   rd_addr,
    output logic                          rd_busy,
    output ffsd_pkg::slot_entry_t         rdata
);
    import ffsd_pkg::*;

    slot_entry_t       mem [NSLOTS];
    logic [NSLOTS-1:0] busy_reg;
    logic [NSLOTS-1:0] busy_next;

    // Set or clear the busy flag of the written slot.
    always_comb begin
        busy_next = busy_reg;
        if (cmd.set_busy) begin
            busy_next[cmd.wr_addr] = 1'b1;
        end else if (cmd.clr_busy) begin
            busy_next[cmd.wr_addr] = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= '0;
        end else begin
            busy_reg <= busy_next;
        end
    end

    // Registered read, single write port.
    always_ff @(posedge aclk) begin
        if (cmd.wr_en) begin
            mem[cmd.wr_addr] <= wdata;
        end
        rdata <= mem[rd_addr];
    end

    assign rd_busy = busy_reg[rd_addr];

endmodule

@@ rtl/core/ffsd_result.sv @@
// Result stage: one held word plus the output register, marks the last word.
module ffsd_result (
    input  logic               aclk,
    input  logic               aresetn,
    input  ffsd_pkg::res_cmd_t cmd,
    input  ffsd_pkg::out_t     data,
    output logic               room,
    output logic               m_valid,
    input  logic               m_ready,
    output ffsd_pkg::out_t     m_data
);
    import ffsd_pkg::*;

    logic hold_valid_reg;
    logic hold_valid_next;
    out_t hold_reg;
    logic m_valid_reg;
    logic m_valid_next;
    out_t m_data_reg;
    out_t move_data;
    logic out_free;
    logic move;

    // The held word goes out once the next one arrives or the item ends.
    assign out_free = !m_valid_reg || m_ready;
    assign room     = !hold_valid_reg || out_free;
    assign move     = (cmd.push || cmd.flush) && hold_valid_reg && out_free;

    always_comb begin
        m_valid_next = m_valid_reg && !m_ready;
        if (move) begin
            m_valid_next = 1'b1;
        end
        hold_valid_next = hold_valid_reg;
        if (cmd.push && room) begin
            hold_valid_next = 1'b1;
        end else if (cmd.flush && room) begin
            hold_valid_next = 1'b0;
        end
    end

    // The word leaving the hold is the last one when the item is closing.
    always_comb begin
        move_data      = hold_reg;
        move_data.last = cmd.flush;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.push && room) begin
            hold_reg <= data;
        end
        if (move) begin
            m_data_reg <= move_data;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

@@ rtl/core/ffsd_ctrl.sv @@
// Sequencer: enqueue on a submit; on a tick, slot sweep, first-fit search, dequeue and dispatch.
module ffsd_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  ffsd_pkg::in_t               s_data,
    input  ffsd_pkg::ring_stat_t        ring_stat,
    input  ffsd_pkg::ring_entry_t       ring_q,
    output ffsd_pkg::ring_cmd_t         ring_cmd,
    output ffsd_pkg::ring_entry_t       ring_wdata,
    input  logic                        slot_busy,
    input  ffsd_pkg::slot_entry_t       slot_q,
    output ffsd_pkg::slot_cmd_t         slot_cmd,
    output ffsd_pkg::slot_entry_t       slot_wdata,
    output logic [ffsd_pkg::SLOT_W-1:0] slot_rd_addr,
    input  logic                        res_room,
    output ffsd_pkg::res_cmd_t          res_cmd,
    output ffsd_pkg::out_t              res_data
);
    import ffsd_pkg::*;

    state_t             state_reg;
    state_t             state_next;
    logic [SLOT_W-1:0]  slot_reg;
    logic [SLOT_W-1:0]  slot_next;
    logic [IDX_W-1:0]   cpu_reg;
    logic [IDX_W-1:0]   cpu_next;
    logic [IDX_W-1:0]   core_reg;
    logic [IDX_W-1:0]   core_next;
    logic [IDX_W-1:0]   thr_reg;
    logic [IDX_W-1:0]   thr_next;
    logic               free_found_reg;
    logic               free_found_next;
    logic [SLOT_W-1:0]  free_slot_reg;
    logic [IDX_W-1:0]   free_cpu_reg;
    logic [IDX_W-1:0]   free_core_reg;
    logic [IDX_W-1:0]   free_thr_reg;
    logic [15:0]        proc_reg;
    logic               accept;
    logic               last_slot;
    logic [15:0]        rem_dec;
    logic               rem_zero;
    logic               eval_done;
    logic               take_free;
    logic [IDX_W-1:0]   thr_inc;
    logic [IDX_W-1:0]   core_inc;
    logic [IDX_W-1:0]   cpu_inc;
    logic               advance;

    assign accept    = s_valid && s_ready;
    assign last_slot = (slot_reg == SLOT_W'(NSLOTS - 1));
    assign rem_dec   = slot_q.remaining - 16'd1;
    assign rem_zero  = (rem_dec == 16'd0);
    assign eval_done = !rem_zero || res_room;

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = (s_data.op == OP_SUBMIT) ? ST_FLUSH : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (slot_busy) begin
                    state_next = ST_EVAL;
                end else if (last_slot) begin
                    state_next = ST_DEQ;
                end
            end
            ST_EVAL: begin
                if (eval_done) begin
                    state_next = last_slot ? ST_DEQ : ST_SCAN;
                end
            end
            ST_DEQ: begin
                state_next = ring_stat.empty ? ST_FLUSH : ST_DISP;
            end
            ST_DISP: begin
                if (res_room) begin
                    state_next = (free_found_reg && ring_q.life == 16'd0) ? ST_ZFIN
                                                                          : ST_FLUSH;
                end
            end
            ST_ZFIN: begin
                if (res_room) begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH: begin
                if (res_room) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs toward the ring, the slot table and the result stage.
    always_comb begin
        s_ready      = (state_reg == ST_IDLE);
        ring_cmd     = '0;
        ring_wdata   = ring_q;
        slot_cmd     = '0;
        slot_wdata   = '0;
        slot_rd_addr = slot_reg;
        res_cmd      = '0;
        res_data     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                ring_wdata.pid  = s_data.pid;
                ring_wdata.life = s_data.lifetime;
                res_data.proc_id = s_data.pid;
                if (accept && s_data.op == OP_SUBMIT) begin
                    res_cmd.push  = 1'b1;
                    ring_cmd.push = !ring_stat.full;
                    res_data.kind = ring_stat.full ? KIND_FULL : KIND_QUEUED;
                end
            end
            ST_EVAL: begin
                slot_cmd.wr_en    = eval_done;
                slot_cmd.wr_addr  = slot_reg;
                slot_cmd.clr_busy = eval_done && rem_zero;
                slot_wdata.owner     = slot_q.owner;
                slot_wdata.remaining = rem_dec;
                res_cmd.push          = rem_zero && res_room;
                res_data.kind         = KIND_FINISHED;
                res_data.proc_id      = slot_q.owner;
                res_data.cpu_index    = cpu_reg[0];
                res_data.core_index   = core_reg[0];
                res_data.thread_index = thr_reg[1:0];
            end
            ST_DISP: begin
                ring_cmd.pop     = res_room;
                ring_cmd.push    = res_room && !free_found_reg;
                res_cmd.push     = res_room;
                res_data.proc_id = ring_q.pid;
                if (free_found_reg) begin
                    res_data.kind         = KIND_DISPATCHED;
                    res_data.cpu_index    = free_cpu_reg[0];
                    res_data.core_index   = free_core_reg[0];
                    res_data.thread_index = free_thr_reg[1:0];
                    slot_cmd.wr_en    = res_room && ring_q.life != 16'd0;
                    slot_cmd.set_busy = res_room && ring_q.life != 16'd0;
                    slot_cmd.wr_addr  = free_slot_reg;
                    slot_wdata.owner     = ring_q.pid;
                    slot_wdata.remaining = ring_q.life;
                end else begin
                    res_data.kind = KIND_REQUEUED;
                end
            end
            ST_ZFIN: begin
                res_cmd.push          = res_room;
                res_data.kind         = KIND_FINISHED;
                res_data.proc_id      = proc_reg;
                res_data.cpu_index    = free_cpu_reg[0];
                res_data.core_index   = free_core_reg[0];
                res_data.thread_index = free_thr_reg[1:0];
            end
            ST_FLUSH: begin
                res_cmd.flush = 1'b1;
            end
            ST_SCAN, ST_DEQ: begin
                res_cmd = '0;
            end
            default: begin
                res_cmd = '0;
            end
        endcase
    end

    // Slot sweep counter with its CPU, core and thread digits.
    always_comb begin
        thr_inc  = (thr_reg == IDX_W'(THREADS - 1)) ? '0 : thr_reg + 1'b1;
        core_inc = core_reg;
        cpu_inc  = cpu_reg;
        if (thr_reg == IDX_W'(THREADS - 1)) begin
            core_inc = (core_reg == IDX_W'(CORES - 1)) ? '0 : core_reg + 1'b1;
            if (core_reg == IDX_W'(CORES - 1)) begin
                cpu_inc = (cpu_reg == IDX_W'(CPUS - 1)) ? '0 : cpu_reg + 1'b1;
            end
        end
        advance = ((state_reg == ST_SCAN) && !slot_busy)
               || ((state_reg == ST_EVAL) && eval_done);
        // The first slot that ends the sweep free is the first-fit target.
        take_free = !free_found_reg
                 && (((state_reg == ST_SCAN) && !slot_busy)
                  || ((state_reg == ST_EVAL) && eval_done && rem_zero));
        slot_next       = slot_reg;
        thr_next        = thr_reg;
        core_next       = core_reg;
        cpu_next        = cpu_reg;
        free_found_next = free_found_reg || take_free;
        if (accept) begin
            slot_next       = '0;
            thr_next        = '0;
            core_next       = '0;
            cpu_next        = '0;
            free_found_next = 1'b0;
        end else if (advance && !last_slot) begin
            slot_next = slot_reg + 1'b1;
            thr_next  = thr_inc;
            core_next = core_inc;
            cpu_next  = cpu_inc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            free_found_reg <= 1'b0;
        end else begin
            state_reg      <= state_next;
            free_found_reg <= free_found_next;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
        thr_reg  <= thr_next;
        core_reg <= core_next;
        cpu_reg  <= cpu_next;
        if (take_free) begin
            free_slot_reg <= slot_reg;
            free_thr_reg  <= thr_reg;
            free_core_reg <= core_reg;
            free_cpu_reg  <= cpu_reg;
        end
        if (state_reg == ST_DISP) begin
            proc_reg <= ring_q.pid;
        end
    end

endmodule

@@ rtl/core/fifo_first_free_slot_dispatcher_unit.sv @@
// Top level of the first-fit process dispatcher.
// A submit word enqueues a process in the ready ring (or reports the ring
// full), and the item then closes. A tick word sweeps every thread slot in
// order, a free slot in the scan state alone and a busy slot through the
// scan and evaluate states of the slot memory's read-modify-write,
// reporting each slot that finishes; the lowest free slot is found during
// that sweep. A dequeue state and, when the ring holds a process, a
// dispatch state follow, a zero-finish state for a dispatched zero-lifetime
// process, and a closing state ends the item; the finish, dispatch and
// closing steps wait while the result side stalls. The ready ring and slot
// table come out of reset empty and need no clearing pass.
module fifo_first_free_slot_dispatcher_unit (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  ffsd_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output ffsd_pkg::out_t m_data
);
    import ffsd_pkg::*;

    ring_cmd_t         ring_cmd;
    ring_entry_t       ring_wdata;
    ring_stat_t        ring_stat;
    ring_entry_t       ring_q;
    slot_cmd_t         slot_cmd;
    slot_entry_t       slot_wdata;
    slot_entry_t       slot_q;
    logic [SLOT_W-1:0] slot_rd_addr;
    logic              slot_busy;
    res_cmd_t          res_cmd;
    out_t              res_data;
    logic              res_room;

    ffsd_ctrl u_ctrl (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .ring_stat    (ring_stat),
        .ring_q       (ring_q),
        .ring_cmd     (ring_cmd),
        .ring_wdata   (ring_wdata),
        .slot_busy    (slot_busy),
        .slot_q       (slot_q),
        .slot_cmd     (slot_cmd),
        .slot_wdata   (slot_wdata),
        .slot_rd_addr (slot_rd_addr),
        .res_room     (res_room),
        .res_cmd      (res_cmd),
        .res_data     (res_data)
    );

    ffsd_ring u_ring (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ring_cmd),
        .wdata   (ring_wdata),
        .stat    (ring_stat),
        .rdata   (ring_q)
    );

    ffsd_slot_table u_slots (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (slot_cmd),
        .wdata   (slot_wdata),
        .rd_addr (slot_rd_addr),
        .rd_busy (slot_busy),
        .rdata   (slot_q)
    );

    ffsd_result u_result (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (res_cmd),
        .data    (res_data),
        .room    (res_room),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ rtl/core/ffsd_checker.sv @@
// Port-level checker of the dispatcher and its bind to the top level.
`include "fifo_first_free_slot_dispatcher_unit_macros.svh"

module ffsd_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input ffsd_pkg::in_t  s_data,
    input logic           m_valid,
    input logic           m_ready,
    input ffsd_pkg::out_t m_data
);
    import ffsd_pkg::*;

    // A stalled result word holds.
    `FFSD_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data))

    // Queued, full and requeued reports always end their item.
    `FFSD_ASSERT_NOW(a_single_last, aclk, aresetn, m_valid && m_data.kind != KIND_DISPATCHED && m_data.kind != KIND_FINISHED, m_data.last)

    // While an item's results are still coming, no new word is taken.
    `FFSD_ASSERT_NOW(a_busy_no_accept, aclk, aresetn, m_valid && !m_data.last, !s_ready)

    // An accepted word keeps the input closed in the following cycle.
    `FFSD_ASSERT_NEXT(a_accept_closes, aclk, aresetn, s_valid && s_ready, !s_ready)

endmodule

bind fifo_first_free_slot_dispatcher_unit ffsd_checker u_checker (.*);
